// ===== hdl/wcp_pkg.sv =====
// ----------------------------------------------------------------------------
// wcp_pkg
// Shared constants, codes and word types for the wall column projection.
// ----------------------------------------------------------------------------
package wcp_pkg;

  // Screen and scene geometry
  localparam int SCREEN_HEIGHT = 512;
  localparam int TILE_PIXELS   = 64;
  localparam int TEXTURE_SIZE  = 64;
  localparam int ANGLE_BITS    = 12;

  // Field widths
  localparam int COL_W    = 10;
  localparam int DIST_W   = 20;
  localparam int ANGLE_W  = 12;
  localparam int HIT_W    = 20;
  localparam int PD_W     = 24;
  localparam int ROW_W    = 10;
  localparam int SEL_W    = 2;
  localparam int TEXCOL_W = 6;
  localparam int TEXROW_W = 22;

  localparam logic [PD_W-1:0]     PD_RESET   = 24'd226816;
  localparam logic [TEXROW_W-1:0] TEXROW_MAX = '1;

  // Angle and cosine arithmetic
  localparam int MAG_W     = ANGLE_BITS;
  localparam int MAGSQ_W   = 2 * MAG_W;
  localparam int HALF      = 1 << (ANGLE_BITS - 1);
  localparam int QUARTER   = HALF / 2;
  localparam int HH_W      = 2 * (ANGLE_BITS - 1) + 1;
  localparam int COS_NUM_W = HH_W + 15;
  localparam int COS_DEN_W = HH_W + 1;
  localparam int COS_W     = 16;
  localparam int PROD_W    = DIST_W + COS_W;

  // Height and texture walk arithmetic
  localparam int TILE_W      = $clog2(TILE_PIXELS + 1);
  localparam int TEX_W       = $clog2(TEXTURE_SIZE + 1);
  localparam int HT_NUM_W    = PD_W + TILE_W + 8;
  localparam int HT_W        = 32;
  localparam int OFF_W       = HT_W + 1 - 9;
  localparam int STEP_NUM_W  = TEX_W + 24;
  localparam int START_NUM_W = OFF_W + TEX_W + 24;

  localparam int QUEUE_DEPTH = 2;

  // Texture select codes
  localparam logic [SEL_W-1:0] SEL_H_UP    = 2'd0;
  localparam logic [SEL_W-1:0] SEL_H_DOWN  = 2'd1;
  localparam logic [SEL_W-1:0] SEL_V_RIGHT = 2'd2;
  localparam logic [SEL_W-1:0] SEL_V_LEFT  = 2'd3;

  typedef struct packed {
    logic [COL_W-1:0]    col;
    logic [DIST_W-1:0]   ray_dist;
    logic [SEL_W-1:0]    sel;
    logic [TEXCOL_W-1:0] texcol;
    logic                sat_ang;
    logic [MAGSQ_W-1:0]  mag_sq;
  } front_word_t;

  typedef struct packed {
    logic [COL_W-1:0]    column_out;
    logic [ROW_W-1:0]    wall_top;
    logic [ROW_W-1:0]    wall_end;
    logic [SEL_W-1:0]    texture_select;
    logic [TEXCOL_W-1:0] texel_column;
    logic [TEXROW_W-1:0] texel_row_start;
    logic [TEXROW_W-1:0] texel_row_step;
    logic                height_saturated;
  } result_t;

endpackage

// ===== hdl/wcp_div.sv =====
// ----------------------------------------------------------------------------
// wcp_div
// Pipelined restoring divider, one quotient bit per stage, with overflow flag
// when the quotient does not fit in QW bits. Carries a sideband word along.
// ----------------------------------------------------------------------------
module wcp_div #(
  parameter int NW = 38,
  parameter int DW = 24,
  parameter int QW = 16,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [SW-1:0] side_in,
  output logic          out_valid,
  output logic [QW-1:0] quo,
  output logic          ovf,
  output logic [SW-1:0] side_out
);

  localparam int RW = NW - QW;
  localparam int CW = (RW > DW) ? RW : DW;

  logic          in_v;
  logic [NW-1:0] num_r;
  logic [DW-1:0] den_r;
  logic [SW-1:0] side_r;
  logic [CW-1:0] rem0_x;
  logic [CW-1:0] den_x;

  logic          s_v    [QW+1];
  logic [DW-1:0] s_rem  [QW+1];
  logic [DW-1:0] s_den  [QW+1];
  logic [QW-1:0] s_lo   [QW+1];
  logic [QW-1:0] s_q    [QW+1];
  logic          s_ovf  [QW+1];
  logic [SW-1:0] s_side [QW+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else begin
      in_v <= in_valid;
    end
    num_r  <= num;
    den_r  <= den;
    side_r <= side_in;
  end

  assign rem0_x = CW'(num_r[NW-1:QW]);
  assign den_x  = CW'(den_r);

  // high part of the numerator decides overflow; low part is shifted in
  always_ff @(posedge clk) begin
    if (rst) begin
      s_v[0] <= 1'b0;
    end else begin
      s_v[0] <= in_v;
    end
    s_rem[0]  <= rem0_x[DW-1:0];
    s_den[0]  <= den_r;
    s_lo[0]   <= num_r[QW-1:0];
    s_q[0]    <= '0;
    s_ovf[0]  <= (rem0_x >= den_x);
    s_side[0] <= side_r;
  end

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [DW:0] trial;
    logic        ge;

    assign trial = {s_rem[k], s_lo[k][QW-1]};
    assign ge    = (trial >= {1'b0, s_den[k]});

    always_ff @(posedge clk) begin
      if (rst) begin
        s_v[k+1] <= 1'b0;
      end else begin
        s_v[k+1] <= s_v[k];
      end
      s_rem[k+1]  <= ge ? DW'(trial - {1'b0, s_den[k]}) : trial[DW-1:0];
      s_den[k+1]  <= s_den[k];
      s_lo[k+1]   <= {s_lo[k][QW-2:0], 1'b0};
      s_q[k+1]    <= {s_q[k][QW-2:0], ge};
      s_ovf[k+1]  <= s_ovf[k];
      s_side[k+1] <= s_side[k];
    end
  end

  assign out_valid = s_v[QW];
  assign quo       = s_q[QW];
  assign ovf       = s_ovf[QW];
  assign side_out  = s_side[QW];

endmodule

// ===== hdl/wcp_front.sv =====
// ----------------------------------------------------------------------------
// wcp_front
// Accepts a ray, folds the angle, flags rays at or past a quarter turn,
// picks the texture and texel column, and hands the word to the queue.
// ----------------------------------------------------------------------------
module wcp_front (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic [wcp_pkg::COL_W-1:0]            column,
  input  logic [wcp_pkg::DIST_W-1:0]           ray_distance,
  input  logic signed [wcp_pkg::ANGLE_W-1:0]   angle_offset,
  input  logic                                 hit_vertical,
  input  logic                                 facing_up,
  input  logic                                 facing_right,
  input  logic [wcp_pkg::HIT_W-1:0]            hit_position,
  input  logic                                 q_full,
  output logic                                 busy,
  output logic                                 push,
  output wcp_pkg::front_word_t                 word
);

  localparam int AB         = wcp_pkg::ANGLE_BITS;
  localparam int TILE_Q8    = wcp_pkg::TILE_PIXELS * 256;
  localparam int TILE_Q8_LG = $clog2(TILE_Q8);

  logic                          front_v;
  logic                          accept;
  logic [15:0]                   ang_ext;
  logic [AB-1:0]                 aw;
  logic [wcp_pkg::MAG_W-1:0]     mag;
  logic [wcp_pkg::HIT_W-1:0]     tile_rem;
  logic [31:0]                   texcol_full;
  logic [wcp_pkg::SEL_W-1:0]     sel;
  wcp_pkg::front_word_t          word_next;

  assign busy   = front_v && q_full;
  assign push   = front_v && !q_full;
  assign accept = start && !busy;

  // sign-extend, then wrap to the angle width and fold to a magnitude
  assign ang_ext = {{(16 - wcp_pkg::ANGLE_W){angle_offset[wcp_pkg::ANGLE_W-1]}}, angle_offset};
  assign aw      = ang_ext[AB-1:0];
  assign mag     = aw[AB-1] ? (AB'(0) - aw) : aw;

  always_comb begin
    if (hit_vertical) begin
      sel = facing_right ? wcp_pkg::SEL_V_RIGHT : wcp_pkg::SEL_V_LEFT;
    end else begin
      sel = facing_up ? wcp_pkg::SEL_H_UP : wcp_pkg::SEL_H_DOWN;
    end
  end

  // tile size is a power of two: mask for the remainder, shift for the scale
  assign tile_rem    = hit_position & wcp_pkg::HIT_W'(TILE_Q8 - 1);
  assign texcol_full = (32'(tile_rem) * 32'(wcp_pkg::TEXTURE_SIZE)) >> TILE_Q8_LG;

  always_comb begin
    word_next.col      = column;
    word_next.ray_dist = ray_distance;
    word_next.sel      = sel;
    word_next.texcol   = texcol_full[wcp_pkg::TEXCOL_W-1:0];
    word_next.sat_ang  = (mag >= wcp_pkg::MAG_W'(wcp_pkg::QUARTER));
    word_next.mag_sq   = wcp_pkg::MAGSQ_W'(mag) * wcp_pkg::MAGSQ_W'(mag);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front_v <= 1'b0;
    end else if (accept) begin
      front_v <= 1'b1;
    end else if (push) begin
      front_v <= 1'b0;
    end
    if (accept) begin
      word <= word_next;
    end
  end

endmodule

// ===== hdl/wcp_queue.sv =====
// ----------------------------------------------------------------------------
// wcp_queue
// Short queue of classified words between the front and the back.
// ----------------------------------------------------------------------------
module wcp_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  wcp_pkg::front_word_t wdata,
  input  logic                 pop,
  output logic                 full,
  output logic                 valid,
  output wcp_pkg::front_word_t rdata
);

  localparam int DEPTH = wcp_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  wcp_pkg::front_word_t mem [DEPTH];
  logic [PTR_W-1:0]     wr_ptr;
  logic [PTR_W-1:0]     rd_ptr;
  logic [CNT_W-1:0]     count;

  assign full  = (count == CNT_W'(DEPTH));
  assign valid = (count != '0);
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) full |-> !push)
    else $error("word pushed into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> valid)
    else $error("word popped from empty queue");
  a_push_shows: assert property (@(posedge clk) disable iff (rst)
    (push && count == '0) |=> valid)
    else $error("pushed word not visible");

endmodule

// ===== hdl/wcp_back.sv =====
// ----------------------------------------------------------------------------
// wcp_back
// Carries out the projection: cosine divide, fisheye multiply, height divide,
// slice clamp, then texture walk divides, one word per cycle.
// ----------------------------------------------------------------------------
module wcp_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_valid,
  input  wcp_pkg::front_word_t        q_word,
  input  logic [wcp_pkg::PD_W-1:0]    projection_distance,
  output logic                        pop,
  output logic                        done,
  output wcp_pkg::result_t            result
);

  localparam int HT_W   = wcp_pkg::HT_W;
  localparam int WIDE_W = HT_W + 2;
  localparam int ROW_W  = wcp_pkg::ROW_W;

  typedef struct packed {
    logic [wcp_pkg::COL_W-1:0]    col;
    logic [wcp_pkg::DIST_W-1:0]   ray_dist;
    logic [wcp_pkg::SEL_W-1:0]    sel;
    logic [wcp_pkg::TEXCOL_W-1:0] texcol;
    logic                         sat_ang;
  } cos_side_t;

  typedef struct packed {
    logic [wcp_pkg::COL_W-1:0]    col;
    logic [wcp_pkg::SEL_W-1:0]    sel;
    logic [wcp_pkg::TEXCOL_W-1:0] texcol;
    logic                         sat;
  } ht_side_t;

  typedef struct packed {
    logic [wcp_pkg::COL_W-1:0]    col;
    logic [ROW_W-1:0]             top;
    logic [ROW_W-1:0]             bottom;
    logic [wcp_pkg::SEL_W-1:0]    sel;
    logic [wcp_pkg::TEXCOL_W-1:0] texcol;
    logic                         sat;
    logic                         hz;
  } tex_side_t;

  localparam logic [wcp_pkg::HH_W-1:0] HH = wcp_pkg::HH_W'(1) << (wcp_pkg::HH_W - 1);
  localparam logic [WIDE_W-1:0] SH256 = WIDE_W'(wcp_pkg::SCREEN_HEIGHT * 256);
  localparam logic [WIDE_W-1:0] SH_ROWS = WIDE_W'(wcp_pkg::SCREEN_HEIGHT);
  localparam logic [wcp_pkg::TEXROW_W-1:0] SAT_START =
    wcp_pkg::TEXROW_W'((wcp_pkg::TEXTURE_SIZE / 2) << 16);

  // cosine divide
  logic [wcp_pkg::HH_W-1:0]      cos_diff;
  logic [wcp_pkg::COS_NUM_W-1:0] cos_num;
  logic [wcp_pkg::COS_DEN_W-1:0] cos_den;
  cos_side_t                     cos_side;
  cos_side_t                     cos_side_o;
  logic                          cos_v;
  logic [wcp_pkg::COS_W-1:0]     cos_q;

  // fisheye multiply
  logic                          m_v;
  logic [wcp_pkg::PROD_W-1:0]    m_prod;
  cos_side_t                     m_side;
  logic [wcp_pkg::DIST_W-1:0]    corr;

  // height divide
  logic [wcp_pkg::HT_NUM_W-9:0]  pd_tile;
  logic [wcp_pkg::HT_NUM_W-1:0]  ht_num;
  ht_side_t                      ht_side;
  ht_side_t                      ht_side_o;
  logic                          ht_v;
  logic [HT_W-1:0]               ht_q;
  logic                          ht_ovf;
  logic [HT_W-1:0]               height;
  logic [WIDE_W-1:0]             ht_ext;
  logic [WIDE_W-1:0]             top_full;
  logic [WIDE_W-1:0]             bot_full;

  // slice stage
  logic                          t_v;
  logic [HT_W-1:0]               t_height;
  logic [ROW_W-1:0]              t_top;
  logic [ROW_W-1:0]              t_bottom;
  ht_side_t                      t_side;
  logic [WIDE_W-1:0]             pos;
  logic [WIDE_W-1:0]             off_full;
  logic [wcp_pkg::OFF_W-1:0]     off;
  logic [wcp_pkg::OFF_W+wcp_pkg::TEX_W-1:0] off_tex;
  logic [wcp_pkg::START_NUM_W-1:0] start_num;
  logic [wcp_pkg::STEP_NUM_W-1:0]  step_num;
  tex_side_t                     tx_side;
  tex_side_t                     tx_side_o;
  logic                          tx_v;
  logic [wcp_pkg::TEXROW_W-1:0]  start_q;
  logic                          start_ovf;
  logic [wcp_pkg::TEXROW_W-1:0]  step_q;
  logic                          step_ovf;

  assign pop = q_valid;

  assign cos_diff = HH - {q_word.mag_sq[wcp_pkg::HH_W-3:0], 2'b00};
  assign cos_num  = q_word.sat_ang ? '0 : {cos_diff, 15'b0};
  assign cos_den  = wcp_pkg::COS_DEN_W'(HH) + wcp_pkg::COS_DEN_W'(q_word.mag_sq);

  always_comb begin
    cos_side.col      = q_word.col;
    cos_side.ray_dist = q_word.ray_dist;
    cos_side.sel      = q_word.sel;
    cos_side.texcol   = q_word.texcol;
    cos_side.sat_ang  = q_word.sat_ang;
  end

  wcp_div #(
    .NW(wcp_pkg::COS_NUM_W), .DW(wcp_pkg::COS_DEN_W), .QW(wcp_pkg::COS_W),
    .SW($bits(cos_side_t))
  ) u_cos_div (
    .clk(clk), .rst(rst), .in_valid(q_valid), .num(cos_num), .den(cos_den),
    .side_in(cos_side), .out_valid(cos_v), .quo(cos_q), .ovf(),
    .side_out(cos_side_o)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_v <= 1'b0;
    end else begin
      m_v <= cos_v;
    end
    m_prod <= wcp_pkg::PROD_W'(cos_side_o.ray_dist) * wcp_pkg::PROD_W'(cos_q);
    m_side <= cos_side_o;
  end

  assign corr    = m_prod[15 +: wcp_pkg::DIST_W];
  assign pd_tile = (wcp_pkg::HT_NUM_W - 8)'(projection_distance)
                   * (wcp_pkg::HT_NUM_W - 8)'(wcp_pkg::TILE_PIXELS);
  assign ht_num  = {pd_tile, 8'b0};

  always_comb begin
    ht_side.col    = m_side.col;
    ht_side.sel    = m_side.sel;
    ht_side.texcol = m_side.texcol;
    ht_side.sat    = m_side.sat_ang || (corr == '0);
  end

  wcp_div #(
    .NW(wcp_pkg::HT_NUM_W), .DW(wcp_pkg::DIST_W), .QW(HT_W),
    .SW($bits(ht_side_t))
  ) u_height_div (
    .clk(clk), .rst(rst), .in_valid(m_v), .num(ht_num), .den(corr),
    .side_in(ht_side), .out_valid(ht_v), .quo(ht_q), .ovf(ht_ovf),
    .side_out(ht_side_o)
  );

  // cap height, then center and clamp the slice
  assign height   = ht_ovf ? '1 : ht_q;
  assign ht_ext   = WIDE_W'(height);
  assign top_full = (ht_ext >= SH256) ? '0 : ((SH256 - ht_ext) >> 9);
  assign bot_full = (SH256 + ht_ext) >> 9;

  always_ff @(posedge clk) begin
    if (rst) begin
      t_v <= 1'b0;
    end else begin
      t_v <= ht_v;
    end
    t_height <= height;
    t_top    <= top_full[ROW_W-1:0];
    t_bottom <= (bot_full > SH_ROWS) ? SH_ROWS[ROW_W-1:0] : bot_full[ROW_W-1:0];
    t_side   <= ht_side_o;
  end

  // texture row at wall_top, in screen rows
  assign pos      = WIDE_W'({t_top, 9'b0}) + WIDE_W'(t_height);
  assign off_full = (pos > SH256) ? ((pos - SH256) >> 9) : '0;
  assign off      = off_full[wcp_pkg::OFF_W-1:0];
  assign off_tex  = (wcp_pkg::OFF_W + wcp_pkg::TEX_W)'(off)
                    * (wcp_pkg::OFF_W + wcp_pkg::TEX_W)'(wcp_pkg::TEXTURE_SIZE);
  assign start_num = {off_tex, 24'b0};
  assign step_num  = wcp_pkg::STEP_NUM_W'(wcp_pkg::TEXTURE_SIZE) << 24;

  always_comb begin
    tx_side.col    = t_side.col;
    tx_side.top    = t_top;
    tx_side.bottom = t_bottom;
    tx_side.sel    = t_side.sel;
    tx_side.texcol = t_side.texcol;
    tx_side.sat    = t_side.sat;
    tx_side.hz     = (t_height == '0);
  end

  wcp_div #(
    .NW(wcp_pkg::START_NUM_W), .DW(HT_W), .QW(wcp_pkg::TEXROW_W),
    .SW($bits(tex_side_t))
  ) u_start_div (
    .clk(clk), .rst(rst), .in_valid(t_v), .num(start_num), .den(t_height),
    .side_in(tx_side), .out_valid(tx_v), .quo(start_q), .ovf(start_ovf),
    .side_out(tx_side_o)
  );

  wcp_div #(
    .NW(wcp_pkg::STEP_NUM_W), .DW(HT_W), .QW(wcp_pkg::TEXROW_W), .SW(1)
  ) u_step_div (
    .clk(clk), .rst(rst), .in_valid(t_v), .num(step_num), .den(t_height),
    .side_in(1'b0), .out_valid(), .quo(step_q), .ovf(step_ovf),
    .side_out()
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= tx_v;
    end
    result.column_out       <= tx_side_o.col;
    result.texture_select   <= tx_side_o.sel;
    result.texel_column     <= tx_side_o.texcol;
    result.height_saturated <= tx_side_o.sat;
    priority if (tx_side_o.sat) begin
      result.wall_top        <= '0;
      result.wall_end        <= SH_ROWS[ROW_W-1:0];
      result.texel_row_start <= SAT_START;
      result.texel_row_step  <= '0;
    end else if (tx_side_o.hz) begin
      result.wall_top        <= tx_side_o.top;
      result.wall_end        <= tx_side_o.bottom;
      result.texel_row_start <= '0;
      result.texel_row_step  <= wcp_pkg::TEXROW_MAX;
    end else begin
      result.wall_top        <= tx_side_o.top;
      result.wall_end        <= tx_side_o.bottom;
      result.texel_row_start <= start_ovf ? wcp_pkg::TEXROW_MAX : start_q;
      result.texel_row_step  <= step_ovf ? wcp_pkg::TEXROW_MAX : step_q;
    end
  end

endmodule

// ===== hdl/wall_column_projection.sv =====
// ----------------------------------------------------------------------------
// wall_column_projection
// Per-column wall slice projection for a grid raycaster.
// ----------------------------------------------------------------------------
// Path: an accepted ray is registered, queued, then runs through the three
//   bit-per-stage divider pipelines (cosine, height, texture walk) to done.
// Throughput: one ray per cycle; busy stays low since results cannot stall.
// Reset: rst clears all valid flags and the queue, and loads
//   projection_distance with its default.
// ----------------------------------------------------------------------------
module wall_column_projection (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [wcp_pkg::COL_W-1:0]           column,
  input  logic [wcp_pkg::DIST_W-1:0]          ray_distance,
  input  logic signed [wcp_pkg::ANGLE_W-1:0]  angle_offset,
  input  logic                                hit_vertical,
  input  logic                                facing_up,
  input  logic                                facing_right,
  input  logic [wcp_pkg::HIT_W-1:0]           hit_position,
  input  logic                                cfg_we,
  input  logic [wcp_pkg::PD_W-1:0]            cfg_data,
  output logic                                done,
  output logic [wcp_pkg::COL_W-1:0]           column_out,
  output logic [wcp_pkg::ROW_W-1:0]           wall_top,
  output logic [wcp_pkg::ROW_W-1:0]           wall_end,
  output logic [wcp_pkg::SEL_W-1:0]           texture_select,
  output logic [wcp_pkg::TEXCOL_W-1:0]        texel_column,
  output logic [wcp_pkg::TEXROW_W-1:0]        texel_row_start,
  output logic [wcp_pkg::TEXROW_W-1:0]        texel_row_step,
  output logic                                height_saturated
);

  logic [wcp_pkg::PD_W-1:0] projection_distance;
  logic                     q_full;
  logic                     push;
  logic                     pop;
  logic                     q_valid;
  wcp_pkg::front_word_t     f_word;
  wcp_pkg::front_word_t     q_word;
  wcp_pkg::result_t         result;

  always_ff @(posedge clk) begin
    if (rst) begin
      projection_distance <= wcp_pkg::PD_RESET;
    end else if (cfg_we) begin
      projection_distance <= cfg_data;
    end
  end

  wcp_front u_front (
    .clk(clk), .rst(rst), .start(start), .column(column),
    .ray_distance(ray_distance), .angle_offset(angle_offset),
    .hit_vertical(hit_vertical), .facing_up(facing_up),
    .facing_right(facing_right), .hit_position(hit_position),
    .q_full(q_full), .busy(busy), .push(push), .word(f_word)
  );

  wcp_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .wdata(f_word), .pop(pop),
    .full(q_full), .valid(q_valid), .rdata(q_word)
  );

  wcp_back u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_word(q_word),
    .projection_distance(projection_distance), .pop(pop), .done(done),
    .result(result)
  );

  assign column_out       = result.column_out;
  assign wall_top         = result.wall_top;
  assign wall_end         = result.wall_end;
  assign texture_select   = result.texture_select;
  assign texel_column     = result.texel_column;
  assign texel_row_start  = result.texel_row_start;
  assign texel_row_step   = result.texel_row_step;
  assign height_saturated = result.height_saturated;

  a_never_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("front stalled although the back never stalls");

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the wall column projection: rays are sent through
// the command port with random gaps, every result is predicted in the bench
// and compared field by field, and the projection register is swept.
// ----------------------------------------------------------------------------
module tb;

  localparam int LATENCY = 80;

  typedef struct {
    logic [wcp_pkg::COL_W-1:0]          column;
    logic [wcp_pkg::DIST_W-1:0]         ray_distance;
    logic signed [wcp_pkg::ANGLE_W-1:0] angle_offset;
    logic                               hit_vertical;
    logic                               facing_up;
    logic                               facing_right;
    logic [wcp_pkg::HIT_W-1:0]          hit_position;
    logic                               is_cfg;
    logic [wcp_pkg::PD_W-1:0]           cfg_value;
  } ray_t;

  logic clk, rst, start, busy, cfg_we, done;
  logic [wcp_pkg::COL_W-1:0] column, column_out;
  logic [wcp_pkg::DIST_W-1:0] ray_distance;
  logic signed [wcp_pkg::ANGLE_W-1:0] angle_offset;
  logic hit_vertical, facing_up, facing_right, height_saturated;
  logic [wcp_pkg::HIT_W-1:0] hit_position;
  logic [wcp_pkg::PD_W-1:0] cfg_data;
  logic [wcp_pkg::ROW_W-1:0] wall_top, wall_end;
  logic [wcp_pkg::SEL_W-1:0] texture_select;
  logic [wcp_pkg::TEXCOL_W-1:0] texel_column;
  logic [wcp_pkg::TEXROW_W-1:0] texel_row_start, texel_row_step;

  ray_t pending_rays[$];
  wcp_pkg::result_t slices_due[$];
  logic [wcp_pkg::PD_W-1:0] proj_dist;
  int errors = 0;
  int gap = 0;
  int quiet = 0;

  wall_column_projection DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .column(column), .ray_distance(ray_distance), .angle_offset(angle_offset),
    .hit_vertical(hit_vertical), .facing_up(facing_up),
    .facing_right(facing_right), .hit_position(hit_position),
    .cfg_we(cfg_we), .cfg_data(cfg_data), .done(done),
    .column_out(column_out), .wall_top(wall_top), .wall_end(wall_end),
    .texture_select(texture_select), .texel_column(texel_column),
    .texel_row_start(texel_row_start), .texel_row_step(texel_row_step),
    .height_saturated(height_saturated)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  function automatic logic [63:0] sat_row(logic [63:0] v);
    return (v > 64'h3FFFFF) ? 64'h3FFFFF : v;
  endfunction

  function automatic wcp_pkg::result_t project_slice(ray_t r,
                                                     logic [wcp_pkg::PD_W-1:0] pd);
    wcp_pkg::result_t s;
    logic [63:0] turn, half, aw, mag, hh, aa, cosq, corr, height, top, bot;
    logic [63:0] pos, off, sh, tile_q8, texcol, start_v, step_v;
    logic sat;
    turn = 64'd1 << wcp_pkg::ANGLE_BITS;
    half = turn >> 1;
    sh = 64'(wcp_pkg::SCREEN_HEIGHT) * 64'd256;
    aw = {{(64 - wcp_pkg::ANGLE_W){r.angle_offset[wcp_pkg::ANGLE_W-1]}}, r.angle_offset}
         & (turn - 64'd1);
    mag = (aw >= half) ? turn - aw : aw;
    sat = 1'b0;
    corr = '0;
    if (mag * 64'd2 >= half) begin
      sat = 1'b1;
    end else begin
      hh = half * half;
      aa = mag * mag;
      cosq = ((hh - 64'd4 * aa) << 15) / (hh + aa);
      corr = (64'(r.ray_distance) * cosq) >> 15;
      if (corr == 0) sat = 1'b1;
    end
    s.column_out = r.column;
    if (!r.hit_vertical) begin
      s.texture_select = r.facing_up ? wcp_pkg::SEL_H_UP : wcp_pkg::SEL_H_DOWN;
    end else begin
      s.texture_select = r.facing_right ? wcp_pkg::SEL_V_RIGHT : wcp_pkg::SEL_V_LEFT;
    end
    tile_q8 = 64'(wcp_pkg::TILE_PIXELS) << 8;
    texcol = ((64'(r.hit_position) % tile_q8) * 64'(wcp_pkg::TEXTURE_SIZE)) / tile_q8;
    s.texel_column = texcol[wcp_pkg::TEXCOL_W-1:0];
    s.height_saturated = sat;
    if (sat) begin
      s.wall_top = '0;
      s.wall_end = wcp_pkg::ROW_W'(wcp_pkg::SCREEN_HEIGHT);
      s.texel_row_step = '0;
      s.texel_row_start = wcp_pkg::TEXROW_W'((wcp_pkg::TEXTURE_SIZE / 2) << 16);
    end else begin
      height = ((64'(wcp_pkg::TILE_PIXELS) * 64'(pd)) << 8) / corr;
      if (height > 64'hFFFFFFFF) height = 64'hFFFFFFFF;
      top = (height >= sh) ? 64'd0 : (sh - height) >> 9;
      bot = (sh + height) >> 9;
      if (bot > 64'(wcp_pkg::SCREEN_HEIGHT)) bot = 64'(wcp_pkg::SCREEN_HEIGHT);
      s.wall_top = top[wcp_pkg::ROW_W-1:0];
      s.wall_end = bot[wcp_pkg::ROW_W-1:0];
      if (height == 0) begin
        s.texel_row_start = '0;
        s.texel_row_step = wcp_pkg::TEXROW_MAX;
      end else begin
        pos = top * 64'd512 + height;
        off = (pos > sh) ? (pos - sh) >> 9 : 64'd0;
        step_v = sat_row((64'(wcp_pkg::TEXTURE_SIZE) << 24) / height);
        start_v = sat_row(((off * 64'(wcp_pkg::TEXTURE_SIZE)) << 24) / height);
        s.texel_row_step = step_v[wcp_pkg::TEXROW_W-1:0];
        s.texel_row_start = start_v[wcp_pkg::TEXROW_W-1:0];
      end
    end
    return s;
  endfunction

  function automatic ray_t random_ray();
    ray_t r;
    int k;
    r.is_cfg = 1'b0;
    r.cfg_value = '0;
    r.column = wcp_pkg::COL_W'($urandom);
    r.hit_vertical = 1'($urandom);
    r.facing_up = 1'($urandom);
    r.facing_right = 1'($urandom);
    r.hit_position = wcp_pkg::HIT_W'($urandom);
    k = $urandom_range(0, 9);
    // mostly in-view angles and modest distances, some anything
    if (k < 7) r.angle_offset = wcp_pkg::ANGLE_W'(int'($urandom_range(0, 1020)) - 510);
    else r.angle_offset = wcp_pkg::ANGLE_W'($urandom);
    k = $urandom_range(0, 9);
    if (k < 4) r.ray_distance = wcp_pkg::DIST_W'($urandom_range(1, 4095));
    else if (k < 8) r.ray_distance = wcp_pkg::DIST_W'($urandom_range(1, 65535));
    else r.ray_distance = wcp_pkg::DIST_W'($urandom);
    return r;
  endfunction

  function automatic ray_t make_ray(int d, int a, int hv, int up, int rt, int hp);
    ray_t r;
    r.is_cfg = 1'b0;
    r.cfg_value = '0;
    r.column = wcp_pkg::COL_W'($urandom);
    r.ray_distance = wcp_pkg::DIST_W'(d);
    r.angle_offset = wcp_pkg::ANGLE_W'(a);
    r.hit_vertical = 1'(hv);
    r.facing_up = 1'(up);
    r.facing_right = 1'(rt);
    r.hit_position = wcp_pkg::HIT_W'(hp);
    return r;
  endfunction

  function automatic ray_t cfg_marker(logic [wcp_pkg::PD_W-1:0] v);
    ray_t r;
    r = make_ray(0, 0, 0, 0, 0, 0);
    r.is_cfg = 1'b1;
    r.cfg_value = v;
    return r;
  endfunction

  initial begin
    logic [wcp_pkg::PD_W-1:0] pd_values[6];
    pd_values = '{24'd226816, 24'd0, 24'hFFFFFF, 24'd256, 24'd1, 24'd40000};
    // directed: field extremes, every texture, angle limits, zero distance
    pending_rays.push_back(make_ray(0, 0, 0, 1, 0, 0));
    pending_rays.push_back(make_ray(20'hFFFFF, 0, 0, 0, 1, 20'hFFFFF));
    pending_rays.push_back(make_ray(256, 0, 1, 0, 1, 16383));
    pending_rays.push_back(make_ray(256, 0, 1, 1, 0, 16384));
    pending_rays.push_back(make_ray(1, 0, 1, 0, 0, 100));
    pending_rays.push_back(make_ray(1, 5, 0, 1, 1, 8191));
    pending_rays.push_back(make_ray(1000, 511, 0, 1, 1, 777));
    pending_rays.push_back(make_ray(1000, 512, 0, 1, 1, 777));
    pending_rays.push_back(make_ray(1000, -512, 1, 1, 1, 777));
    pending_rays.push_back(make_ray(1000, -511, 1, 0, 1, 777));
    pending_rays.push_back(make_ray(1000, 2047, 0, 0, 0, 1));
    pending_rays.push_back(make_ray(1000, -2048, 1, 1, 1, 2));
    pending_rays.push_back(make_ray(64, 0, 0, 0, 0, 3));
    pending_rays.push_back(make_ray(16384, 300, 1, 0, 0, 4));
    foreach (pd_values[i]) begin
      if (i > 0) pending_rays.push_back(cfg_marker(pd_values[i]));
      pending_rays.push_back(make_ray(1, 0, 0, 1, 0, 5));
      pending_rays.push_back(make_ray(20'hFFFFF, 100, 1, 0, 0, 6));
      for (int n = 0; n < 320; n++) pending_rays.push_back(random_ray());
    end
    pending_rays.push_back(cfg_marker(wcp_pkg::PD_W'($urandom)));
    for (int n = 0; n < 30; n++) pending_rays.push_back(random_ray());
  end

  // driver: one word per accepted start, config only when the pipe is empty
  always @(posedge clk) begin : drive
    ray_t r;
    logic took;
    logic cfg_fire;
    took = start && !busy;
    cfg_fire = 1'b0;
    if (rst) begin
      start <= 0;
      cfg_we <= 0;
      proj_dist <= wcp_pkg::PD_RESET;
      quiet <= 0;
    end else begin
      if (took) begin
        slices_due.push_back(project_slice(pending_rays.pop_front(), proj_dist));
        quiet <= 0;
      end else begin
        quiet <= quiet + 1;
      end
      if (gap > 0) begin
        gap <= gap - 1;
        start <= 0;
      end else if (pending_rays.size() > 0) begin
        r = pending_rays[0];
        if (r.is_cfg) begin
          start <= 0;
          if (!took && slices_due.size() == 0 && quiet > LATENCY + 4) begin
            cfg_fire = 1'b1;
            cfg_data <= r.cfg_value;
            proj_dist <= r.cfg_value;
            void'(pending_rays.pop_front());
          end
        end else begin
          start <= 1;
          column <= r.column;
          ray_distance <= r.ray_distance;
          angle_offset <= r.angle_offset;
          hit_vertical <= r.hit_vertical;
          facing_up <= r.facing_up;
          facing_right <= r.facing_right;
          hit_position <= r.hit_position;
          if ($urandom_range(0, 3) == 0)
            gap <= ($urandom_range(0, 9) == 0) ? int'($urandom_range(10, 120))
                                               : int'($urandom_range(1, 3));
        end
      end else begin
        start <= 0;
      end
      cfg_we <= cfg_fire;
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && done) begin
      if (slices_due.size() == 0) begin
        $error("result with none expected, column %0d", column_out);
        errors = errors + 1;
      end else begin
        wcp_pkg::result_t e;
        e = slices_due.pop_front();
        if (e.column_out !== column_out) begin
          $error("column_out exp %0d got %0d", e.column_out, column_out);
          errors = errors + 1;
        end
        if (e.wall_top !== wall_top) begin
          $error("wall_top exp %0d got %0d", e.wall_top, wall_top);
          errors = errors + 1;
        end
        if (e.wall_end !== wall_end) begin
          $error("wall_end exp %0d got %0d", e.wall_end, wall_end);
          errors = errors + 1;
        end
        if (e.texture_select !== texture_select) begin
          $error("texture_select exp %0d got %0d", e.texture_select, texture_select);
          errors = errors + 1;
        end
        if (e.texel_column !== texel_column) begin
          $error("texel_column exp %0d got %0d", e.texel_column, texel_column);
          errors = errors + 1;
        end
        if (e.texel_row_start !== texel_row_start) begin
          $error("texel_row_start exp %0h got %0h", e.texel_row_start, texel_row_start);
          errors = errors + 1;
        end
        if (e.texel_row_step !== texel_row_step) begin
          $error("texel_row_step exp %0h got %0h", e.texel_row_step, texel_row_step);
          errors = errors + 1;
        end
        if (e.height_saturated !== height_saturated) begin
          $error("height_saturated exp %0d got %0d", e.height_saturated, height_saturated);
          errors = errors + 1;
        end
      end
    end
  end

  initial begin
    rst = 1;
    start = 0;
    cfg_we = 0;
    cfg_data = 0;
    column = 0;
    ray_distance = 0;
    angle_offset = 0;
    hit_vertical = 0;
    facing_up = 0;
    facing_right = 0;
    hit_position = 0;
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    wait (pending_rays.size() == 0 && !start);
    wait (slices_due.size() == 0);
    repeat (LATENCY + 20) @(posedge clk);
    if (errors == 0 && slices_due.size() == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("CHECKS FAILED");
    $finish;
  end
endmodule
